@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Condition that must hold on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`endif

@@ rtl/tamr_pkg.sv @@
// Package for tensor_axis_max_reduce: widths, constants, float max helpers.
// No dependencies.
package tamr_pkg;

  localparam int unsigned MAX_INNER_DEF = 1024;
  localparam int unsigned LEN_W = 17;
  localparam int unsigned POS_W = 16;
  localparam int unsigned INNER_CFG_W = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [LEN_W-1:0] LEN_CAP = 17'd65536;
  localparam logic [31:0] NEG_INF_BITS = 32'hFF800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTER = 2'd0,
    REG_AXIS  = 2'd1,
    REG_INNER = 2'd2,
    REG_NONE  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic first;
    logic emit;
    logic final_item;
  } issue_t;

  function automatic logic is_nan(input logic [31:0] b);
    is_nan = b[30:0] > 31'h7F800000;
  endfunction

  function automatic logic [31:0] order_key(input logic [31:0] b);
    if (b[30:0] == 31'd0) order_key = 32'h80000000;
    else if (b[31]) order_key = ~b;
    else order_key = b | 32'h80000000;
  endfunction

  function automatic logic [31:0] fold_max(input logic [31:0] stored, input logic [31:0] x);
    if (is_nan(x)) fold_max = stored;
    else if (is_nan(stored)) fold_max = x;
    else fold_max = (order_key(x) > order_key(stored)) ? x : stored;
  endfunction

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v,
                                               input logic [LEN_W-1:0] cap);
    if (v == '0) eff_len = LEN_W'(1);
    else eff_len = (v > cap) ? cap : v;
  endfunction

endpackage

@@ rtl/tamr_index.sv @@
// Position counters and per-item flags for the axis max reduction.
// Depends on tamr_pkg.
module tamr_index #(
  parameter int unsigned MAX_INNER = tamr_pkg::MAX_INNER_DEF,
  parameter int unsigned IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic [tamr_pkg::LEN_W-1:0] outer_count,
  input  logic [tamr_pkg::LEN_W-1:0] axis_len,
  input  logic [tamr_pkg::INNER_CFG_W-1:0] inner_len,
  output logic [IW-1:0] slot,
  output tamr_pkg::issue_t issue
);

  localparam logic [tamr_pkg::LEN_W-1:0] INNER_CAP = tamr_pkg::LEN_W'(MAX_INNER);

  logic [IW-1:0] inner_pos;
  logic [tamr_pkg::POS_W-1:0] axis_pos;
  logic [tamr_pkg::POS_W-1:0] outer_pos;
  logic [tamr_pkg::LEN_W-1:0] n_outer, n_axis, n_inner;
  logic inner_last, axis_last, outer_last;

  always_comb begin
    n_outer = tamr_pkg::eff_len(outer_count, tamr_pkg::LEN_CAP);
    n_axis = tamr_pkg::eff_len(axis_len, tamr_pkg::LEN_CAP);
    n_inner = tamr_pkg::eff_len(tamr_pkg::LEN_W'(inner_len), INNER_CAP);
    inner_last = (tamr_pkg::LEN_W'(inner_pos) + 1'b1) >= n_inner;
    axis_last = (tamr_pkg::LEN_W'(axis_pos) + 1'b1) >= n_axis;
    outer_last = (tamr_pkg::LEN_W'(outer_pos) + 1'b1) >= n_outer;
    slot = (tamr_pkg::LEN_W'(inner_pos) < INNER_CAP) ? inner_pos : '0;
    issue.first = (axis_pos == '0);
    issue.emit = axis_last;
    issue.final_item = axis_last && inner_last && outer_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_pos <= '0;
      axis_pos <= '0;
      outer_pos <= '0;
    end else if (adv) begin
      if (!inner_last) begin
        inner_pos <= inner_pos + 1'b1;
      end else begin
        inner_pos <= '0;
        if (!axis_last) begin
          axis_pos <= axis_pos + 1'b1;
        end else begin
          axis_pos <= '0;
          outer_pos <= outer_last ? '0 : outer_pos + 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/tamr_buffer.sv @@
// Running-max buffer: one write port, one read port with registered data.
// Depends on tamr_pkg.
module tamr_buffer #(
  parameter int unsigned MAX_INNER = tamr_pkg::MAX_INNER_DEF,
  parameter int unsigned IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
  input  logic clk,
  input  logic rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [31:0] rd_data,
  input  logic wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [31:0] wr_data
);

  logic [31:0] mem [MAX_INNER];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

@@ rtl/tensor_axis_max_reduce.sv @@
// Top level of the axis max reduction: config registers, fold stage, output register.
// Depends on tamr_pkg, tamr_index, tamr_buffer and assert_macros.svh.
//
// Usage:
//   Elements enter on in_valid/in_stall in row-major order of an
//   outer_count x axis_len x inner_len tensor. Each element of the last axis
//   slice yields one item on out_valid/out_stall: the maximum for its inner
//   position, with last_result set on the final item of the tensor.
//   Registers are written on cfg_valid/cfg_ready (index 0 outer_count,
//   1 axis_len, 2 inner_len); cfg_ready is always high. The user must
//   write them only while the block is idle; the block does not enforce it.
//   Throughput: one element per cycle unless the output stalls, set by the
//   single read-modify-write of the buffer memory, with a bypass for
//   back-to-back hits on one entry. If the receiver stalls with a result held,
//   the fold stage holds its item and in_stall rises until the output register
//   frees. Reset clears counters and valid flags and loads all lengths with 1;
//   the buffer needs no clearing, as each entry is loaded on the first slice.
`include "assert_macros.svh"
module tensor_axis_max_reduce #(
  parameter int unsigned MAX_INNER = tamr_pkg::MAX_INNER_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [31:0] element,
  output logic out_valid,
  input  logic out_stall,
  output logic [31:0] max_value,
  output logic last_result,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [tamr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tamr_pkg::LEN_W-1:0] cfg_data
);

  localparam int unsigned IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

  logic [tamr_pkg::LEN_W-1:0] outer_count, axis_len;
  logic [tamr_pkg::INNER_CFG_W-1:0] inner_len;

  logic adv, in_acc, wr_en;
  logic [IW-1:0] slot;
  tamr_pkg::issue_t issue;

  logic s1_valid;
  tamr_pkg::issue_t s1_issue;
  logic [31:0] s1_elem;
  logic [IW-1:0] s1_slot;
  logic s1_byp;
  logic [31:0] s1_byp_data;
  logic [31:0] rd_data, base, m;

  assign cfg_ready = 1'b1;
  assign adv = !out_valid || !out_stall;
  assign in_stall = s1_valid && !adv;
  assign in_acc = in_valid && !in_stall;
  assign wr_en = s1_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_count <= tamr_pkg::LEN_W'(1);
      axis_len <= tamr_pkg::LEN_W'(1);
      inner_len <= tamr_pkg::INNER_CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (tamr_pkg::cfg_reg_t'(cfg_index))
        tamr_pkg::REG_OUTER: outer_count <= cfg_data;
        tamr_pkg::REG_AXIS:  axis_len <= cfg_data;
        tamr_pkg::REG_INNER: inner_len <= cfg_data[tamr_pkg::INNER_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  tamr_index #(.MAX_INNER(MAX_INNER), .IW(IW)) u_index (
    .clk(clk), .rst(rst), .adv(in_acc),
    .outer_count(outer_count), .axis_len(axis_len), .inner_len(inner_len),
    .slot(slot), .issue(issue)
  );

  tamr_buffer #(.MAX_INNER(MAX_INNER), .IW(IW)) u_buffer (
    .clk(clk), .rd_en(in_acc), .rd_addr(slot), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(s1_slot), .wr_data(m)
  );

  always_comb begin
    base = s1_issue.first ? tamr_pkg::NEG_INF_BITS : (s1_byp ? s1_byp_data : rd_data);
    m = tamr_pkg::fold_max(base, s1_elem);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_issue <= issue;
      s1_elem <= element;
      s1_slot <= slot;
      s1_byp <= wr_en && (s1_slot == slot);
      s1_byp_data <= m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid && s1_issue.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && s1_issue.emit) begin
      max_value <= m;
      last_result <= s1_issue.final_item;
    end
  end

  `ASSERT_IMPL(a_stall_has_item, clk, rst, in_stall |-> s1_valid)
  `ASSERT_IMPL(a_held_item_stays, clk, rst, (s1_valid && !adv) |=> s1_valid)
  `ASSERT_IMPL(a_bypass_after_write, clk, rst, (in_acc && wr_en && s1_slot == slot) |=> s1_byp)

endmodule
